// ===== sv/tsfm_pkg.sv =====
`timescale 1ns / 1ps
package tsfm_pkg;

  localparam int SAMPLE_BITS = 12;
  localparam int COORD_BITS  = 10;
  localparam int FRAC_BITS   = 24;
  localparam int COEF_W      = 32;
  localparam int ADDR_W      = 5;
  localparam int CNT_W       = $clog2(SAMPLE_BITS);
  // coefficient times zero-extended sample
  localparam int PROD_W      = COEF_W + SAMPLE_BITS + 1;
  localparam int ACC_W       = PROD_W + 1;

  localparam logic signed [PROD_W-1:0] PRESS_LIMIT = PROD_W'(4 << SAMPLE_BITS);

  localparam logic [2:0] REG_COEF_XX = 3'd0;
  localparam logic [2:0] REG_COEF_XY = 3'd1;
  localparam logic [2:0] REG_COEF_XO = 3'd2;
  localparam logic [2:0] REG_COEF_YX = 3'd3;
  localparam logic [2:0] REG_COEF_YY = 3'd4;
  localparam logic [2:0] REG_COEF_YO = 3'd5;

  typedef struct packed {
    logic                   pen_down;
    logic [SAMPLE_BITS-1:0] pressure_one;
    logic [SAMPLE_BITS-1:0] pressure_two;
    logic [SAMPLE_BITS-1:0] raw_x_first;
    logic [SAMPLE_BITS-1:0] raw_x_second;
    logic [SAMPLE_BITS-1:0] raw_x_third;
    logic [SAMPLE_BITS-1:0] raw_y_first;
    logic [SAMPLE_BITS-1:0] raw_y_second;
    logic [SAMPLE_BITS-1:0] raw_y_third;
  } in_word_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] screen_x;
    logic [COORD_BITS-1:0] screen_y;
    logic                  is_press;
  } out_word_t;

  function automatic logic [SAMPLE_BITS-1:0] med3(input logic [SAMPLE_BITS-1:0] a,
                                                   input logic [SAMPLE_BITS-1:0] b,
                                                   input logic [SAMPLE_BITS-1:0] c);
    logic [SAMPLE_BITS-1:0] lo;
    logic [SAMPLE_BITS-1:0] hi;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    if (c <= lo) begin
      return lo;
    end else if (c >= hi) begin
      return hi;
    end
    return c;
  endfunction

endpackage

// ===== sv/tsfm_div.sv =====
`timescale 1ns / 1ps
module tsfm_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [tsfm_pkg::SAMPLE_BITS-1:0] dividend,
  input  logic [tsfm_pkg::SAMPLE_BITS-1:0] divisor,
  output logic                             done,
  output logic [tsfm_pkg::SAMPLE_BITS-1:0] quotient
);
  import tsfm_pkg::*;

  logic                   busy_r;
  logic                   done_r;
  logic [CNT_W-1:0]       cnt_r;
  logic [SAMPLE_BITS-1:0] rem_r;
  logic [SAMPLE_BITS-1:0] quo_r;
  logic [SAMPLE_BITS:0]   rem_sh;
  logic [SAMPLE_BITS:0]   diff;

  // restoring division, one quotient bit per cycle
  always_comb begin
    rem_sh = {rem_r, quo_r[SAMPLE_BITS-1]};
    diff   = rem_sh - {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(SAMPLE_BITS - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end else begin
        done_r <= 1'b0;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
    end else if (busy_r) begin
      rem_r <= diff[SAMPLE_BITS] ? rem_sh[SAMPLE_BITS-1:0] : diff[SAMPLE_BITS-1:0];
      quo_r <= {quo_r[SAMPLE_BITS-2:0], ~diff[SAMPLE_BITS]};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ===== sv/touch_sample_filter_and_map.sv =====
`timescale 1ns / 1ps
// resistive touch sample filter and screen mapper
// input channel (in_valid/in_ready/in_data) takes one sample set per word:
// pen-down bit, pressures z1/z2 and three raw X and Y readings
// output channel (out_valid/out_ready/out_data) gives at most one word per
// sample: a press with the mapped position, or a release with the last one
// apb port writes six signed q8.24 coefficients at byte addresses 0..20
// pen down: median of each triple, z2/z1 on a bit-serial divider,
// then a pressure test and four coefficient products on one shared 32x13
// multiplier; a press word goes to the output register, and then the block
// is ready to take the next sample set
// pressure test fails: no word, and the block goes back to idle
// release: the held position goes through the emit step to the output register
// zero z1 or pen-up with no press pending: ready again the next cycle
// the result sits in an output register; a stalled receiver holds the block
// in its emit step until the register frees up
// reset clears the coefficients, the touch state and the output valid
module touch_sample_filter_and_map (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  tsfm_pkg::in_word_t            in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output tsfm_pkg::out_word_t           out_data,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tsfm_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import tsfm_pkg::*;

  localparam int A5_W = SAMPLE_BITS + 5;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_DIV  = 6'b000010,
    ST_TMUL = 6'b000100,
    ST_TCMP = 6'b001000,
    ST_MAP  = 6'b010000,
    ST_EMIT = 6'b100000
  } state_t;

  state_t                     state_r;
  logic [CNT_W-1:0]           cnt_r;
  logic [SAMPLE_BITS-1:0]     z1_r;
  logic [SAMPLE_BITS-1:0]     x_r;
  logic [SAMPLE_BITS-1:0]     y_r;
  logic signed [PROD_W-1:0]   p_r;
  logic signed [ACC_W-1:0]    acc_r;
  logic [COORD_BITS-1:0]      sx_r;
  logic [COORD_BITS-1:0]      sy_r;
  logic                       press_r;
  logic                       touch_active_r;
  logic                       out_valid_r;
  out_word_t                  out_data_r;
  logic signed [COEF_W-1:0]   coef_xx_r;
  logic signed [COEF_W-1:0]   coef_xy_r;
  logic signed [COEF_W-1:0]   coef_xo_r;
  logic signed [COEF_W-1:0]   coef_yx_r;
  logic signed [COEF_W-1:0]   coef_yy_r;
  logic signed [COEF_W-1:0]   coef_yo_r;

  logic                       in_fire;
  logic                       div_start;
  logic                       div_done;
  logic [SAMPLE_BITS-1:0]     quot;
  logic signed [SAMPLE_BITS+1:0] qm1;
  logic signed [A5_W-1:0]     a5;
  logic signed [COEF_W-1:0]   mul_a;
  logic [SAMPLE_BITS-1:0]     mul_b;
  logic signed [PROD_W-1:0]   prod;
  logic                       slot_free;

  function automatic logic [COORD_BITS-1:0] sat_coord(input logic signed [ACC_W-1:0] a);
    if (a[ACC_W-1]) begin
      return '0;
    end else if (|a[ACC_W-2:FRAC_BITS+COORD_BITS]) begin
      return '1;
    end
    return a[FRAC_BITS+COORD_BITS-1:FRAC_BITS];
  endfunction

  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign div_start = in_fire && in_data.pen_down && (in_data.pressure_one != '0);
  assign slot_free = !out_valid_r || out_ready;

  tsfm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (in_data.pressure_two),
    .divisor  (z1_r),
    .done     (div_done),
    .quotient (quot)
  );

  // shared multiplier operand select
  always_comb begin
    qm1   = $signed({2'b00, quot}) - (SAMPLE_BITS + 2)'(1);
    a5    = (A5_W'(qm1) <<< 2) + A5_W'(qm1);
    mul_a = coef_xx_r;
    mul_b = x_r;
    if (state_r == ST_TMUL) begin
      mul_a = COEF_W'(a5);
      mul_b = x_r;
    end else begin
      case (cnt_r)
        CNT_W'(1): begin
          mul_a = coef_xy_r;
          mul_b = y_r;
        end
        CNT_W'(2): begin
          mul_a = coef_yx_r;
          mul_b = x_r;
        end
        CNT_W'(3): begin
          mul_a = coef_yy_r;
          mul_b = y_r;
        end
        default: begin
          mul_a = coef_xx_r;
          mul_b = x_r;
        end
      endcase
    end
    prod = mul_a * $signed({1'b0, mul_b});
  end

  always_ff @(posedge clk) begin
    p_r <= prod;
    if (in_fire) begin
      z1_r <= in_data.pressure_one;
      x_r  <= med3(in_data.raw_x_first, in_data.raw_x_second, in_data.raw_x_third);
      y_r  <= med3(in_data.raw_y_first, in_data.raw_y_second, in_data.raw_y_third);
    end
    if (state_r == ST_MAP) begin
      case (cnt_r)
        CNT_W'(0): acc_r <= ACC_W'(coef_xo_r);
        CNT_W'(3): acc_r <= ACC_W'(coef_yo_r) + ACC_W'(p_r);
        default:   acc_r <= acc_r + ACC_W'(p_r);
      endcase
    end
    if (state_r == ST_EMIT && slot_free) begin
      out_data_r.screen_x <= sx_r;
      out_data_r.screen_y <= sy_r;
      out_data_r.is_press <= press_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      cnt_r          <= '0;
      sx_r           <= '0;
      sy_r           <= '0;
      press_r        <= 1'b0;
      touch_active_r <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      if (state_r == ST_EMIT && slot_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            if (!in_data.pen_down) begin
              if (touch_active_r) begin
                // release carries the held position
                touch_active_r <= 1'b0;
                press_r        <= 1'b0;
                state_r        <= ST_EMIT;
              end
            end else if (div_start) begin
              state_r <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          if (div_done) begin
            state_r <= ST_TMUL;
          end
        end
        ST_TMUL: begin
          state_r <= ST_TCMP;
        end
        ST_TCMP: begin
          // 5 * x * (q - 1) against the pressure limit
          if (p_r > PRESS_LIMIT) begin
            state_r <= ST_IDLE;
          end else begin
            cnt_r   <= '0;
            state_r <= ST_MAP;
          end
        end
        ST_MAP: begin
          cnt_r <= cnt_r + CNT_W'(1);
          if (cnt_r == CNT_W'(3)) begin
            sx_r <= sat_coord(acc_r);
          end
          if (cnt_r == CNT_W'(5)) begin
            sy_r    <= sat_coord(acc_r);
            press_r <= 1'b1;
            state_r <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (slot_free) begin
            touch_active_r <= press_r;
            state_r        <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // coefficient registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_xx_r <= '0;
      coef_xy_r <= '0;
      coef_xo_r <= '0;
      coef_yx_r <= '0;
      coef_yy_r <= '0;
      coef_yo_r <= '0;
    end else if (psel && penable && pwrite) begin
      case (paddr[4:2])
        REG_COEF_XX: coef_xx_r <= pwdata;
        REG_COEF_XY: coef_xy_r <= pwdata;
        REG_COEF_XO: coef_xo_r <= pwdata;
        REG_COEF_YX: coef_yx_r <= pwdata;
        REG_COEF_YY: coef_yy_r <= pwdata;
        REG_COEF_YO: coef_yo_r <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_COEF_XX: prdata = coef_xx_r;
      REG_COEF_XY: prdata = coef_xy_r;
      REG_COEF_XO: prdata = coef_xo_r;
      REG_COEF_YX: prdata = coef_yx_r;
      REG_COEF_YY: prdata = coef_yy_r;
      REG_COEF_YO: prdata = coef_yo_r;
      default:     prdata = '0;
    endcase
  end

  assign pready    = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== tb/touch_sample_filter_and_map_tb.sv =====
`timescale 1ns / 1ps
module touch_sample_filter_and_map_tb;
  import tsfm_pkg::*;

  typedef enum logic [1:0] {ROW_CFG, ROW_PREDICT, ROW_NO_RESULT, ROW_TYPED} row_kind_e;
  typedef enum logic [1:0] {SET_CALIB, SET_WILD, SET_EDGE} setting_e;

  typedef struct {
    row_kind_e  kind;
    logic [2:0] reg_idx;
    logic [31:0] value;
    in_word_t   sample;
    out_word_t  typed;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_word_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_word_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  // predictor copy of the block state and coefficients
  logic pen_held = 1'b0;
  logic [COORD_BITS-1:0] last_x = '0;
  logic [COORD_BITS-1:0] last_y = '0;
  logic [31:0] coef_now [6] = '{default: '0};

  out_word_t pending_points[$];
  dir_row_t dir_rows[$];
  int mismatch_count = 0;
  int send_idle_pct = 26;
  int recv_idle_pct = 73;
  int hold_requests = 0;
  int hold_seen = 0;
  int hold_left = 0;

  touch_sample_filter_and_map DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("touch_sample_filter_and_map_tb failed");
    $finish;
  end

  task automatic flag_error(input string msg);
    $display("%0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  function automatic logic [SAMPLE_BITS-1:0] middle_of(input logic [SAMPLE_BITS-1:0] a,
                                                       input logic [SAMPLE_BITS-1:0] b,
                                                       input logic [SAMPLE_BITS-1:0] c);
    logic [SAMPLE_BITS-1:0] small_ab;
    logic [SAMPLE_BITS-1:0] big_ab;
    logic [SAMPLE_BITS-1:0] capped;
    small_ab = (a < b) ? a : b;
    big_ab = (a < b) ? b : a;
    capped = (big_ab < c) ? big_ab : c;
    return (small_ab > capped) ? small_ab : capped;
  endfunction

  function automatic logic [COORD_BITS-1:0] map_coord(input logic [31:0] kx,
                                                      input logic [31:0] ky,
                                                      input logic [31:0] ko,
                                                      input logic [SAMPLE_BITS-1:0] x,
                                                      input logic [SAMPLE_BITS-1:0] y);
    longint acc;
    longint whole;
    acc = longint'($signed(kx)) * longint'(x) + longint'($signed(ky)) * longint'(y)
          + longint'($signed(ko));
    if (acc < 0) begin
      return '0;
    end
    whole = acc >>> FRAC_BITS;
    if (whole > (longint'(1) << COORD_BITS) - 1) begin
      return '1;
    end
    return COORD_BITS'(whole);
  endfunction

  // advances the touch state by one sample set; returns 1 when a word comes out
  function automatic bit predict_touch_word(input in_word_t w, output out_word_t res);
    logic [SAMPLE_BITS-1:0] x;
    logic [SAMPLE_BITS-1:0] y;
    logic [SAMPLE_BITS-1:0] quot;
    longint test;
    res = '0;
    if (!w.pen_down) begin
      if (!pen_held) begin
        return 1'b0;
      end
      pen_held = 1'b0;
      res.screen_x = last_x;
      res.screen_y = last_y;
      res.is_press = 1'b0;
      return 1'b1;
    end
    if (w.pressure_one == '0) begin
      return 1'b0;
    end
    x = middle_of(w.raw_x_first, w.raw_x_second, w.raw_x_third);
    y = middle_of(w.raw_y_first, w.raw_y_second, w.raw_y_third);
    quot = w.pressure_two / w.pressure_one;
    test = 5 * longint'(x) * (longint'(quot) - 1);
    if (test > (longint'(4) << SAMPLE_BITS)) begin
      return 1'b0;
    end
    last_x = map_coord(coef_now[REG_COEF_XX], coef_now[REG_COEF_XY], coef_now[REG_COEF_XO], x, y);
    last_y = map_coord(coef_now[REG_COEF_YX], coef_now[REG_COEF_YY], coef_now[REG_COEF_YO], x, y);
    pen_held = 1'b1;
    res.screen_x = last_x;
    res.screen_y = last_y;
    res.is_press = 1'b1;
    return 1'b1;
  endfunction

  function automatic in_word_t sample_of(input bit pen, input int z1, input int z2,
                                         input int x1, input int x2, input int x3,
                                         input int y1, input int y2, input int y3);
    in_word_t w;
    w.pen_down = pen;
    w.pressure_one = SAMPLE_BITS'(z1);
    w.pressure_two = SAMPLE_BITS'(z2);
    w.raw_x_first = SAMPLE_BITS'(x1);
    w.raw_x_second = SAMPLE_BITS'(x2);
    w.raw_x_third = SAMPLE_BITS'(x3);
    w.raw_y_first = SAMPLE_BITS'(y1);
    w.raw_y_second = SAMPLE_BITS'(y2);
    w.raw_y_third = SAMPLE_BITS'(y3);
    return w;
  endfunction

  function automatic out_word_t point(input int x, input int y, input bit press);
    out_word_t p;
    p.screen_x = COORD_BITS'(x);
    p.screen_y = COORD_BITS'(y);
    p.is_press = press;
    return p;
  endfunction

  function automatic void add_cfg(input logic [2:0] idx, input logic [31:0] value);
    dir_row_t r;
    r.kind = ROW_CFG;
    r.reg_idx = idx;
    r.value = value;
    r.sample = '0;
    r.typed = '0;
    dir_rows.push_back(r);
  endfunction

  function automatic void add_item(input row_kind_e kind, input in_word_t w,
                                   input out_word_t typed);
    dir_row_t r;
    r.kind = kind;
    r.reg_idx = REG_COEF_XX;
    r.value = '0;
    r.sample = w;
    r.typed = typed;
    dir_rows.push_back(r);
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] jitter_reading(input logic [SAMPLE_BITS-1:0] c);
    int v;
    if ($urandom_range(0, 6) == 0) begin
      return SAMPLE_BITS'($urandom());
    end
    v = int'(c) + int'($urandom_range(0, 80)) - 40;
    if (v < 0) begin
      v = 0;
    end
    if (v > 4095) begin
      v = 4095;
    end
    return SAMPLE_BITS'(v);
  endfunction

  function automatic in_word_t touch_sample(input logic [SAMPLE_BITS-1:0] cx,
                                            input logic [SAMPLE_BITS-1:0] cy);
    in_word_t w;
    int z1;
    int z2;
    z1 = ($urandom_range(0, 19) == 0) ? 0 : int'($urandom_range(1, 4095));
    z2 = z1 * int'($urandom_range(0, 3));
    z2 += (z1 > 0) ? int'($urandom_range(0, z1 - 1)) : int'($urandom_range(0, 4095));
    if (z2 > 4095) begin
      z2 = 4095;
    end
    w = sample_of(1'b1, z1, z2, jitter_reading(cx), jitter_reading(cx), jitter_reading(cx),
                  jitter_reading(cy), jitter_reading(cy), jitter_reading(cy));
    return w;
  endfunction

  function automatic in_word_t noise_sample();
    logic [127:0] bits;
    bits = {$urandom(), $urandom(), $urandom(), $urandom()};
    return bits[$bits(in_word_t)-1:0];
  endfunction

  function automatic logic [31:0] draw_coef(input setting_e mode, input logic [2:0] idx);
    logic [31:0] v;
    int off;
    if (mode == SET_WILD) begin
      return $urandom();
    end
    if (mode == SET_EDGE && $urandom_range(0, 3) != 0) begin
      case ($urandom_range(0, 2))
        0: return 32'h8000_0000;
        1: return 32'h7fff_ffff;
        default: return 32'h0000_0000;
      endcase
    end
    if (idx == REG_COEF_XX || idx == REG_COEF_YY) begin
      // roughly 4096 raw counts onto 1024 pixels, sometimes mirrored
      v = $urandom_range(3 << 20, 5 << 20);
      if ($urandom_range(0, 3) == 0) begin
        v = -v;
      end
    end else if (idx == REG_COEF_XO || idx == REG_COEF_YO) begin
      off = int'($urandom_range(0, 200)) - 100;
      v = (32'(off) << FRAC_BITS) + ($urandom() & 32'h00ff_ffff);
    end else begin
      v = $urandom_range(0, 1 << 20) - (1 << 19);
    end
    return v;
  endfunction

  task automatic write_coef(input logic [2:0] idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    coef_now[idx] = value;
    @(posedge clk);
  endtask

  task automatic apply_setting(input setting_e mode);
    logic [2:0] idx;
    for (int r = 0; r < 6; r++) begin
      idx = 3'(r);
      write_coef(idx, draw_coef(mode, idx));
    end
  endtask

  // drain: rejected samples leave no word, so give the pipeline time after the last one
  task automatic settle_block();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_points.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic push_sample(input in_word_t w, input row_kind_e kind, input out_word_t typed);
    out_word_t res;
    bit made;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    made = predict_touch_word(w, res);
    case (kind)
      ROW_TYPED: begin
        pending_points.push_back(typed);
      end
      ROW_NO_RESULT: begin
      end
      default: begin
        if (made) begin
          pending_points.push_back(res);
        end
      end
    endcase
  endtask

  // strokes: a run of pen-down sets around a drifting point, then the pen lifts
  task automatic run_random(input int target);
    int done_items;
    int len;
    logic [SAMPLE_BITS-1:0] cx;
    logic [SAMPLE_BITS-1:0] cy;
    in_word_t w;
    done_items = 0;
    while (done_items < target) begin
      if ($urandom_range(0, 9) == 0) begin
        w = noise_sample();
        push_sample(w, ROW_PREDICT, '0);
        done_items++;
      end else begin
        cx = SAMPLE_BITS'($urandom());
        cy = SAMPLE_BITS'($urandom());
        len = $urandom_range(1, 10);
        repeat (len) begin
          push_sample(touch_sample(cx, cy), ROW_PREDICT, '0);
          cx = cx + SAMPLE_BITS'($urandom_range(0, 60)) - SAMPLE_BITS'(30);
          cy = cy + SAMPLE_BITS'($urandom_range(0, 60)) - SAMPLE_BITS'(30);
          done_items++;
        end
        repeat ($urandom_range(1, 3)) begin
          w = noise_sample();
          w.pen_down = 1'b0;
          push_sample(w, ROW_PREDICT, '0);
          done_items++;
        end
      end
    end
  endtask

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (hold_seen != hold_requests) begin
      hold_seen = hold_requests;
      hold_left = 300;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    out_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_points.size() == 0) begin
        flag_error($sformatf("unexpected word x=%0d y=%0d press=%0b",
                             out_data.screen_x, out_data.screen_y, out_data.is_press));
      end else begin
        want = pending_points.pop_front();
        if (out_data.screen_x !== want.screen_x) begin
          flag_error($sformatf("screen_x got %0d expected %0d",
                               out_data.screen_x, want.screen_x));
        end
        if (out_data.screen_y !== want.screen_y) begin
          flag_error($sformatf("screen_y got %0d expected %0d",
                               out_data.screen_y, want.screen_y));
        end
        if (out_data.is_press !== want.is_press) begin
          flag_error($sformatf("is_press got %0b expected %0b",
                               out_data.is_press, want.is_press));
        end
      end
    end
  end

  initial begin
    setting_e mode;

    // coefficients are zero out of reset, so everything maps to the origin
    add_item(ROW_NO_RESULT, sample_of(0, 4095, 4095, 4095, 4095, 4095, 4095, 4095, 4095), '0);
    add_item(ROW_NO_RESULT, sample_of(1, 0, 4095, 2000, 2000, 2000, 2000, 2000, 2000), '0);
    add_item(ROW_TYPED, sample_of(1, 1, 0, 4095, 0, 4095, 0, 4095, 0), point(0, 0, 1));
    add_item(ROW_TYPED, sample_of(0, 0, 0, 0, 0, 0, 0, 0, 0), point(0, 0, 0));
    add_item(ROW_NO_RESULT, sample_of(0, 0, 0, 0, 0, 0, 0, 0, 0), '0);
    add_item(ROW_TYPED, sample_of(1, 4095, 4095, 4095, 4095, 4095, 4095, 4095, 4095),
             point(0, 0, 1));
    add_item(ROW_TYPED, sample_of(0, 0, 0, 0, 0, 0, 0, 0, 0), point(0, 0, 0));
    // quarter scale with small offsets
    add_cfg(REG_COEF_XX, 32'h0040_0000);
    add_cfg(REG_COEF_XY, 32'h0000_0000);
    add_cfg(REG_COEF_XO, 32'h0a00_0000);
    add_cfg(REG_COEF_YX, 32'h0000_0000);
    add_cfg(REG_COEF_YY, 32'h0040_0000);
    add_cfg(REG_COEF_YO, 32'h0500_0000);
    add_item(ROW_PREDICT, sample_of(1, 100, 150, 100, 3000, 2000, 4000, 50, 800), '0);
    // pressure test just inside and just outside the limit at quotient two
    add_item(ROW_PREDICT, sample_of(1, 1000, 2000, 3276, 3276, 4095, 10, 20, 30), '0);
    add_item(ROW_PREDICT, sample_of(1, 1000, 2000, 3277, 0, 4095, 10, 20, 30), '0);
    add_item(ROW_PREDICT, sample_of(1, 1, 4095, 1, 1, 1, 0, 0, 0), '0);
    add_item(ROW_PREDICT, sample_of(1, 1, 4095, 0, 0, 0, 4095, 4095, 4095), '0);
    add_item(ROW_PREDICT, sample_of(0, 17, 0, 0, 0, 0, 0, 0, 0), '0);
    // extreme coefficients: x saturates high or lands on the offset, y goes negative
    add_cfg(REG_COEF_XX, 32'h7fff_ffff);
    add_cfg(REG_COEF_XY, 32'h7fff_ffff);
    add_cfg(REG_COEF_XO, 32'h7fff_ffff);
    add_cfg(REG_COEF_YX, 32'h8000_0000);
    add_cfg(REG_COEF_YY, 32'h8000_0000);
    add_cfg(REG_COEF_YO, 32'h8000_0000);
    add_item(ROW_TYPED, sample_of(1, 500, 600, 1, 2, 3, 7, 8, 9), point(1023, 0, 1));
    add_item(ROW_TYPED, sample_of(0, 0, 0, 0, 0, 0, 0, 0, 0), point(1023, 0, 0));
    add_item(ROW_TYPED, sample_of(1, 500, 500, 0, 0, 0, 0, 0, 0), point(127, 0, 1));
    add_item(ROW_TYPED, sample_of(0, 0, 0, 0, 0, 0, 0, 0, 0), point(127, 0, 0));
    // negative x offset, mirrored y
    add_cfg(REG_COEF_XX, 32'h0040_0000);
    add_cfg(REG_COEF_XY, 32'h0001_0000);
    add_cfg(REG_COEF_XO, 32'hec00_0000);
    add_cfg(REG_COEF_YX, 32'hffff_0000);
    add_cfg(REG_COEF_YY, 32'hffc0_0000);
    add_cfg(REG_COEF_YO, 32'h7f00_0000);
    add_item(ROW_PREDICT, sample_of(1, 300, 400, 40, 60, 50, 100, 90, 95), '0);
    add_item(ROW_PREDICT, sample_of(1, 300, 400, 2000, 2100, 2050, 300, 310, 305), '0);
    add_item(ROW_PREDICT, sample_of(1, 2048, 4095, 4000, 3990, 3995, 4095, 4000, 4050), '0);
    add_item(ROW_PREDICT, sample_of(0, 0, 0, 0, 0, 0, 0, 0, 0), '0);
    add_item(ROW_NO_RESULT, sample_of(0, 0, 0, 0, 0, 0, 0, 0, 0), '0);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        if (i == 0 || dir_rows[i-1].kind != ROW_CFG) begin
          settle_block();
        end
        write_coef(dir_rows[i].reg_idx, dir_rows[i].value);
      end else begin
        push_sample(dir_rows[i].sample, dir_rows[i].kind, dir_rows[i].typed);
      end
    end

    for (int p = 0; p < 6; p++) begin
      settle_block();
      mode = (p == 1) ? SET_WILD : (p == 3) ? SET_EDGE : SET_CALIB;
      apply_setting(mode);
      send_idle_pct = (p < 2) ? 26 : (p < 4) ? 73 : 0;
      recv_idle_pct <= (p < 2) ? 73 : (p < 4) ? 26 : 0;
      if (p == 0 || p == 4) begin
        hold_requests <= hold_requests + 1;
      end
      run_random(305);
    end

    settle_block();
    if (mismatch_count == 0) begin
      $display("touch_sample_filter_and_map_tb passed");
    end else begin
      $display("touch_sample_filter_and_map_tb failed");
    end
    $finish;
  end

endmodule
